// File: hdl/ccar_pkg.sv
// Shared types and constants of the character class automaton runner.
`default_nettype none

package ccar_pkg;

  localparam int NUM_STATES      = 16;
  localparam int EDGES_PER_STATE = 4;
  localparam int SET_SIZE        = 4;
  localparam int CHAR_WIDTH      = 16;
  localparam int LISTED          = 4;

  localparam int STATE_W = 4;
  localparam int SLOT_W  = 2;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 3;
  localparam int LEN_W   = 16;

  typedef enum logic [2:0] {
    KIND_EDGE  = 3'd0,
    KIND_FINAL = 3'd1,
    KIND_START = 3'd2,
    KIND_CHAR  = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 2'd0,
    MODE_RANGE = 2'd1,
    MODE_ANY   = 2'd2,
    MODE_ANY_B = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [STATE_W-1:0] state_index;
    logic [SLOT_W-1:0]  edge_slot;
    logic [STATE_W-1:0] target_state;
    logic [MODE_W-1:0]  match_mode;
    logic [COUNT_W-1:0] set_count;
    logic               flag;
    logic [15:0]        char_a;
    logic [15:0]        char_b;
    logic [15:0]        char_c;
    logic [15:0]        char_d;
    logic [15:0]        symbol;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [LEN_W-1:0] length;
  } out_item_t;

  // One edge slot as held in the edge memory; the valid bit lives in flops.
  typedef struct packed {
    logic [STATE_W-1:0]                      target;
    logic [MODE_W-1:0]                       mode;
    logic [COUNT_W-1:0]                      count;
    logic [LISTED-1:0][CHAR_WIDTH-1:0]       chars;
  } slot_t;

  typedef slot_t [EDGES_PER_STATE-1:0] row_t;

  typedef struct packed {
    logic               hit;
    logic [STATE_W-1:0] target;
  } match_t;

endpackage

`default_nettype wire

// File: hdl/ccar_in_if.sv
// Input item channel of the automaton runner.
`default_nettype none

interface ccar_in_if;
  logic               valid;
  logic               ready;
  ccar_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/ccar_out_if.sv
// Result channel of the automaton runner.
`default_nettype none

interface ccar_out_if;
  logic                valid;
  logic                ready;
  ccar_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/ccar_match.sv
// Edge row evaluator: tests all slots of a state and picks the first hit.
`default_nettype none

module ccar_match (
  input  ccar_pkg::row_t                          row,
  input  logic [ccar_pkg::EDGES_PER_STATE-1:0]    row_valid,
  input  logic [ccar_pkg::CHAR_WIDTH-1:0]         symbol,
  output ccar_pkg::match_t                        result
);
  import ccar_pkg::*;

  function automatic logic slot_hit(slot_t s, logic [CHAR_WIDTH-1:0] ch);
    logic any_eq;
    any_eq = 1'b0;
    for (int i = 0; i < LISTED; i++) begin
      if (i < SET_SIZE && int'(s.count) > i && s.chars[i] == ch) begin
        any_eq = 1'b1;
      end
    end
    case (s.mode)
      MODE_SET:   slot_hit = any_eq;
      MODE_RANGE: slot_hit = (ch >= s.chars[0]) && (ch <= s.chars[1]);
      default:    slot_hit = 1'b1;
    endcase
  endfunction

  logic [EDGES_PER_STATE-1:0] hits;

  always_comb begin
    for (int i = 0; i < EDGES_PER_STATE; i++) begin
      hits[i] = row_valid[i] && slot_hit(row[i], symbol);
    end
  end

  // Lowest slot wins.
  always_comb begin
    result = '0;
    for (int i = EDGES_PER_STATE - 1; i >= 0; i--) begin
      if (hits[i]) begin
        result.hit    = 1'b1;
        result.target = row[i].target;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/char_class_automaton_runner.sv
// Top level: automaton table in a row memory, run state and result register.
// A character item is handled as an edge memory read of the current state's
// row, then the slot compare and state update in ST_EVAL. Other items need only ST_IDLE.
// An end item's result is valid in the cycle after its transfer and waits in
// a register; other items are still taken while it waits, and only a further
// end item is held off until the waiting result transfers.
// Synchronous reset clears edge valid bits, final flags, run state and the
// result register at once; the edge character memory is not cleared.
`default_nettype none

module char_class_automaton_runner (
  input  logic       clk,
  input  logic       rst,
  ccar_in_if.sink    items,
  ccar_out_if.source results
);
  import ccar_pkg::*;

  typedef enum logic {ST_IDLE, ST_EVAL} state_t;

  state_t state;

  // Edge storage: one row per state, one slot per edge. The slot contents sit
  // in a synchronous memory; the valid bits are flops so that reset empties the
  // table.
  row_t                                        edge_mem [NUM_STATES];
  logic [NUM_STATES-1:0][EDGES_PER_STATE-1:0]  edge_valid;
  logic [NUM_STATES-1:0]                       final_flags;

  // Run state.
  logic [STATE_W-1:0] current_state;
  logic               run_dead;
  logic [LEN_W-1:0]   char_count;

  // Registered row read and the character that goes with it.
  row_t                       row_q;
  logic [EDGES_PER_STATE-1:0] row_valid_q;
  logic [CHAR_WIDTH-1:0]      symbol_q;

  logic      out_valid;
  out_item_t out_data;

  match_t    match;
  logic      in_xfer;
  slot_t     slot_wr;

  // Items are taken only when no character is in evaluation. An end item also
  // needs the result register to be free or emptying, so its result can always
  // land; every other kind passes a waiting result.
  assign items.ready   = (state == ST_IDLE) &&
                         (!out_valid || results.ready || items.data.kind != KIND_END);
  assign in_xfer       = items.valid && items.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_comb begin
    slot_wr.target = items.data.target_state;
    slot_wr.mode   = items.data.match_mode;
    slot_wr.count  = items.data.set_count;
    slot_wr.chars  = {items.data.char_d[CHAR_WIDTH-1:0], items.data.char_c[CHAR_WIDTH-1:0],
                      items.data.char_b[CHAR_WIDTH-1:0], items.data.char_a[CHAR_WIDTH-1:0]};
  end

  // Edge memory: one slot written per edge transfer, one row read per
  // character transfer. A write and a read never share a cycle, and a read
  // always comes after the write it depends on.
  always_ff @(posedge clk) begin
    if (in_xfer && items.data.kind == KIND_EDGE) begin
      edge_mem[items.data.state_index][items.data.edge_slot] <= slot_wr;
    end
    if (in_xfer && items.data.kind == KIND_CHAR) begin
      row_q       <= edge_mem[current_state];
      row_valid_q <= edge_valid[current_state];
      symbol_q    <= items.data.symbol[CHAR_WIDTH-1:0];
    end
  end

  // Valid bits and final flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_valid  <= '0;
      final_flags <= '0;
    end else if (in_xfer) begin
      if (items.data.kind == KIND_EDGE) begin
        edge_valid[items.data.state_index][items.data.edge_slot] <= items.data.flag;
      end
      if (items.data.kind == KIND_FINAL) begin
        final_flags[items.data.state_index] <= items.data.flag;
      end
    end
  end

  ccar_match u_match (
    .row       (row_q),
    .row_valid (row_valid_q),
    .symbol    (symbol_q),
    .result    (match)
  );

  // Control: run state, sequencing of character items and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_state <= '0;
      run_dead      <= 1'b0;
      char_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A result that leaves in the same cycle as a new end transfer is
      // replaced by the new one below, so the register stays full.
      if (results.valid && results.ready && !(in_xfer && items.data.kind == KIND_END)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (items.data.kind)
              KIND_START: begin
                current_state <= items.data.state_index;
                run_dead      <= 1'b0;
                char_count    <= '0;
              end
              KIND_CHAR: begin
                state <= ST_EVAL;
              end
              KIND_END: begin
                out_valid         <= 1'b1;
                out_data.accepted <= !run_dead && final_flags[current_state];
                out_data.length   <= char_count;
              end
              default: ;
            endcase
          end
        end
        ST_EVAL: begin
          // A dead run ignores characters; otherwise take the first hit or die.
          if (!run_dead) begin
            if (match.hit) begin
              current_state <= match.target;
              if (char_count != {LEN_W{1'b1}}) begin
                char_count <= char_count + 1'b1;
              end
            end else begin
              run_dead <= 1'b1;
            end
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/ccar_checker.sv
// Port-level assertions for the automaton runner, bound to the top level.
`default_nettype none

module ccar_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [2:0]            in_kind,
  input logic                  out_valid,
  input logic                  out_ready,
  input ccar_pkg::out_item_t   out_data
);
  import ccar_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("waiting result changed");

  a_char_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_CHAR |=> !in_ready)
    else $error("item taken during character evaluation");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_END |=> out_valid)
    else $error("end transfer gave no result");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_kind == KIND_END))
    else $error("result without end transfer");

endmodule

bind char_class_automaton_runner ccar_checker u_ccar_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_kind   (items.data.kind),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);

`default_nettype wire

// File: test/char_class_automaton_runner_test.sv
// Self-checking testbench of the character class automaton runner.
`timescale 1ns / 100ps

// Keeps a shadow copy of the automaton table and the run state. It works out
// the verdict of every end-of-string item and compares the verdicts that come
// back from the block, oldest first.
class verdict_board;
  bit                               slot_valid  [ccar_pkg::NUM_STATES][ccar_pkg::EDGES_PER_STATE];
  bit [ccar_pkg::STATE_W-1:0]       slot_target [ccar_pkg::NUM_STATES][ccar_pkg::EDGES_PER_STATE];
  bit [ccar_pkg::MODE_W-1:0]        slot_mode   [ccar_pkg::NUM_STATES][ccar_pkg::EDGES_PER_STATE];
  bit [ccar_pkg::COUNT_W-1:0]       slot_count  [ccar_pkg::NUM_STATES][ccar_pkg::EDGES_PER_STATE];
  bit [ccar_pkg::CHAR_WIDTH-1:0]    slot_chars  [ccar_pkg::NUM_STATES][ccar_pkg::EDGES_PER_STATE]
                                                [ccar_pkg::LISTED];
  bit                               final_flag  [ccar_pkg::NUM_STATES];
  bit [ccar_pkg::STATE_W-1:0]       run_state;
  bit                               run_dead;
  bit [ccar_pkg::LEN_W-1:0]         run_length;
  ccar_pkg::out_item_t              due_verdicts [$];
  int                               mismatches;

  // Does the given slot of the given state take this character?
  function bit slot_takes(int st, int sl, bit [ccar_pkg::CHAR_WIDTH-1:0] sym);
    int lim;
    case (slot_mode[st][sl])
      ccar_pkg::MODE_SET: begin
        // Counts beyond the listed characters are clipped; zero never matches.
        lim = slot_count[st][sl];
        if (lim > ccar_pkg::SET_SIZE) lim = ccar_pkg::SET_SIZE;
        if (lim > ccar_pkg::LISTED) lim = ccar_pkg::LISTED;
        for (int i = 0; i < lim; i++)
          if (slot_chars[st][sl][i] == sym) return 1'b1;
        return 1'b0;
      end
      ccar_pkg::MODE_RANGE:
        return sym >= slot_chars[st][sl][0] && sym <= slot_chars[st][sl][1];
      default:
        return 1'b1;
    endcase
  endfunction

  // Applies one accepted input item to the shadow state.
  function void absorb_item(ccar_pkg::in_item_t it);
    ccar_pkg::out_item_t want;
    bit                  hit;
    case (it.kind)
      ccar_pkg::KIND_EDGE: begin
        slot_valid[it.state_index][it.edge_slot]  = it.flag;
        slot_target[it.state_index][it.edge_slot] = it.target_state;
        slot_mode[it.state_index][it.edge_slot]   = it.match_mode;
        slot_count[it.state_index][it.edge_slot]  = it.set_count;
        slot_chars[it.state_index][it.edge_slot][0] = it.char_a;
        slot_chars[it.state_index][it.edge_slot][1] = it.char_b;
        slot_chars[it.state_index][it.edge_slot][2] = it.char_c;
        slot_chars[it.state_index][it.edge_slot][3] = it.char_d;
      end
      ccar_pkg::KIND_FINAL: final_flag[it.state_index] = it.flag;
      ccar_pkg::KIND_START: begin
        run_state  = it.state_index;
        run_dead   = 1'b0;
        run_length = '0;
      end
      ccar_pkg::KIND_CHAR: begin
        if (!run_dead) begin
          hit = 1'b0;
          for (int sl = 0; sl < ccar_pkg::EDGES_PER_STATE && !hit; sl++) begin
            if (slot_valid[run_state][sl] && slot_takes(run_state, sl, it.symbol)) begin
              run_state = slot_target[run_state][sl];
              hit       = 1'b1;
            end
          end
          if (!hit) run_dead = 1'b1;
          else if (run_length != '1) run_length++;
        end
      end
      ccar_pkg::KIND_END: begin
        want.accepted = !run_dead && final_flag[run_state];
        want.length   = run_length;
        due_verdicts.push_back(want);
      end
      default: ;
    endcase
  endfunction

  function void check_verdict(ccar_pkg::out_item_t got);
    ccar_pkg::out_item_t want;
    if (due_verdicts.size() == 0) begin
      $error("unexpected verdict: accepted %0d length %0d", got.accepted, got.length);
      mismatches++;
      return;
    end
    want = due_verdicts.pop_front();
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
      mismatches++;
    end
    if (got.length !== want.length) begin
      $error("length: expected %0d, actual %0d", want.length, got.length);
      mismatches++;
    end
  endfunction
endclass

module char_class_automaton_runner_test;
  import ccar_pkg::*;

  // Number of random items to offer, not counting ignored kinds.
  localparam int RANDOM_ITEMS = 1950;
  // How long the result side holds off once to force the input to stall.
  localparam int HOLD_OFF     = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ccar_in_if  items_if ();
  ccar_out_if results_if ();

  char_class_automaton_runner DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  verdict_board sb = new();

  // Offered items that the block acts on; ignored kinds are left out.
  int item_total = 0;
  // While set, neither side idles: back-to-back transfers.
  bit quiet = 1'b0;
  // Raised once by the stimulus; the result side turns it into a long stall.
  bit hold_off_request = 1'b0;
  bit held_off = 1'b0;

  // 12 ns clock period.
  always #6 clk = ~clk;

  // Idle lengths: mostly none or short, sometimes a long gap.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Every item starts with random content in all fields, so that the fields an
  // item does not use still see both values on every bit.
  function automatic in_item_t base_item(input logic [2:0] k);
    in_item_t it;
    it.kind         = k;
    it.state_index  = STATE_W'($urandom);
    it.edge_slot    = SLOT_W'($urandom);
    it.target_state = STATE_W'($urandom);
    it.match_mode   = MODE_W'($urandom);
    it.set_count    = COUNT_W'($urandom);
    it.flag         = 1'($urandom);
    it.char_a       = 16'($urandom);
    it.char_b       = 16'($urandom);
    it.char_c       = 16'($urandom);
    it.char_d       = 16'($urandom);
    it.symbol       = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t edge_write(input logic [3:0] st, input logic [1:0] sl,
                                          input logic [3:0] tgt, input mode_t mode,
                                          input logic [2:0] cnt, input logic valid,
                                          input logic [15:0] a, b, c, d);
    in_item_t it;
    it = base_item(KIND_EDGE);
    it.state_index  = st;
    it.edge_slot    = sl;
    it.target_state = tgt;
    it.match_mode   = mode;
    it.set_count    = cnt;
    it.flag         = valid;
    it.char_a       = a;
    it.char_b       = b;
    it.char_c       = c;
    it.char_d       = d;
    return it;
  endfunction

  function automatic in_item_t final_write(input logic [3:0] st, input logic fin);
    in_item_t it;
    it = base_item(KIND_FINAL);
    it.state_index = st;
    it.flag        = fin;
    return it;
  endfunction

  function automatic in_item_t start_item(input logic [3:0] st);
    in_item_t it;
    it = base_item(KIND_START);
    it.state_index = st;
    return it;
  endfunction

  function automatic in_item_t char_item(input logic [15:0] sym);
    in_item_t it;
    it = base_item(KIND_CHAR);
    it.symbol = sym;
    return it;
  endfunction

  function automatic in_item_t end_item();
    return base_item(KIND_END);
  endfunction

  // Characters drawn from small pools collide often, which is what sets need;
  // the rest are near the extremes or anywhere in the code space.
  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 7));
      1:       return 16'h0061 + 16'($urandom_range(0, 25));
      2:       return $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                           : 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Most automaton traffic stays within a few states so that runs go deep.
  function automatic logic [3:0] pick_state();
    if ($urandom_range(0, 4) != 0) return 4'($urandom_range(0, 5));
    return 4'($urandom);
  endfunction

  function automatic in_item_t random_edge();
    mode_t       mode;
    int          r;
    logic [15:0] a, b;
    r = $urandom_range(0, 9);
    mode = (r < 4) ? MODE_SET : (r < 7) ? MODE_RANGE : (r < 9) ? MODE_ANY : MODE_ANY_B;
    a = pick_char();
    b = pick_char();
    // Ranges are mostly well ordered; a few stay reversed and never match.
    if (mode == MODE_RANGE && a > b && $urandom_range(0, 5) != 0) {a, b} = {b, a};
    return edge_write(pick_state(), SLOT_W'($urandom), pick_state(), mode,
                      ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 4))
                                                  : 3'($urandom_range(0, 7)),
                      $urandom_range(0, 7) != 0, a, b, pick_char(), pick_char());
  endfunction

  // Picks a character that some valid edge of the current state takes, so
  // that runs usually stay live; now and then any character at all.
  function automatic logic [15:0] pick_symbol();
    int         usable [$];
    int         sl;
    int         lim;
    logic [3:0] st;
    st = sb.run_state;
    if (sb.run_dead || $urandom_range(0, 7) == 0) return pick_char();
    for (int i = 0; i < EDGES_PER_STATE; i++)
      if (sb.slot_valid[st][i]) usable.push_back(i);
    if (usable.size() == 0) return pick_char();
    sl = usable[$urandom_range(0, usable.size() - 1)];
    case (sb.slot_mode[st][sl])
      MODE_SET: begin
        lim = sb.slot_count[st][sl];
        if (lim > LISTED) lim = LISTED;
        if (lim > SET_SIZE) lim = SET_SIZE;
        if (lim == 0) return pick_char();
        return sb.slot_chars[st][sl][$urandom_range(0, lim - 1)];
      end
      MODE_RANGE: begin
        if (sb.slot_chars[st][sl][0] > sb.slot_chars[st][sl][1]) return pick_char();
        return sb.slot_chars[st][sl][0] + 16'($urandom_range(0,
                 sb.slot_chars[st][sl][1] - sb.slot_chars[st][sl][0]));
      end
      default: return pick_char();
    endcase
  endfunction

  // Offers one item and holds it until the block takes it, then idles for a
  // random gap. With no gap, valid simply stays high for the next item.
  task automatic offer_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    items_if.data  <= it;
    items_if.valid <= 1'b1;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sb.absorb_item(it);
    if (it.kind <= KIND_END) item_total++;
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A string: usually a fresh start, a string of characters, the end marker.
  // Sometimes the start is left out so the previous run carries on.
  task automatic run_string();
    int n;
    if ($urandom_range(0, 9) != 0) offer_item(start_item(pick_state()));
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
    repeat (n) offer_item(char_item(pick_symbol()));
    offer_item(end_item());
  endtask

  task automatic rewrite_table();
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 4) != 0) offer_item(random_edge());
      else offer_item(final_write(pick_state(), 1'($urandom)));
    end
  endtask

  // Anything the fields allow, including the kinds that the block ignores.
  task automatic offer_noise();
    repeat ($urandom_range(1, 4)) offer_item(base_item(3'($urandom_range(0, 7))));
  endtask

  // Result side: checks every verdict transfer and stalls at random. Once, on
  // request, it holds off for a long stretch so that a finished verdict waits
  // in the block and the next end marker backs up the input.
  initial begin : verdict_sink
    int stall_left;
    stall_left = 0;
    results_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready) sb.check_verdict(results_if.data);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left = HOLD_OFF;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    items_if.valid = 1'b0;
    items_if.data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // A run before any start begins in state 0, which has no edges yet:
    // the empty string is rejected, and any character kills the run.
    offer_item(end_item());
    offer_item(char_item(16'h0000));
    offer_item(end_item());
    // A final start state accepts the empty string.
    offer_item(final_write(4'd0, 1'b1));
    offer_item(start_item(4'd0));
    offer_item(end_item());
    // State 0: an empty set, a set whose count is clipped to four, a reversed
    // range and a range covering the whole code space, in slot order.
    offer_item(edge_write(4'd0, 2'd0, 4'd1, MODE_SET, 3'd0, 1'b1,
                          16'h0041, 16'h0041, 16'h0041, 16'h0041));
    offer_item(edge_write(4'd0, 2'd1, 4'd2, MODE_SET, 3'd7, 1'b1,
                          16'h0000, 16'h0042, 16'h0043, 16'hFFFF));
    offer_item(edge_write(4'd0, 2'd2, 4'd3, MODE_RANGE, 3'd4, 1'b1,
                          16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    offer_item(edge_write(4'd0, 2'd3, 4'd4, MODE_RANGE, 3'd0, 1'b1,
                          16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // State 2 loops on itself through the fourth mode, MODE_ANY_B (any character).
    offer_item(edge_write(4'd2, 2'd0, 4'd2, MODE_ANY_B, 3'd0, 1'b1,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
    offer_item(final_write(4'd2, 1'b1));
    offer_item(char_item(16'hFFFF));
    offer_item(char_item(16'h1234));
    offer_item(end_item());
    // The end marker leaves the run alone; a further character continues it.
    offer_item(char_item(16'h8000));
    offer_item(end_item());
    // 'A' is only in the empty set, so the full range takes it to state 4,
    // which has no edges: the run dies and the length stops at one.
    offer_item(start_item(4'd0));
    offer_item(char_item(16'h0041));
    offer_item(char_item(16'h0042));
    offer_item(end_item());
    offer_item(base_item(3'd6));
    // Highest state, slot and target, plain any-character mode.
    offer_item(edge_write(4'd15, 2'd3, 4'd15, MODE_ANY, 3'd7, 1'b1,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_item(final_write(4'd15, 1'b1));
    offer_item(start_item(4'd15));
    offer_item(char_item(16'h5A5A));
    offer_item(end_item());

    // Random part: fill the table first, then mostly well-formed strings
    // against it, with table rewrites and noise mixed in.
    item_total = 0;
    repeat (30) offer_item(random_edge());
    repeat (6) offer_item(final_write(pick_state(), 1'($urandom)));
    while (item_total < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 9) == 0);
      if (!held_off && item_total > RANDOM_ITEMS / 2) begin
        // Keep offering strings while the result side holds off.
        held_off = 1'b1;
        hold_off_request = 1'b1;
        repeat (4) run_string();
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: rewrite_table();
          5, 6, 7:       offer_noise();
          default:       run_string();
        endcase
      end
    end
    quiet = 1'b0;
    items_if.valid <= 1'b0;

    // Drain: every verdict in, then an idle wait to catch stray ones.
    while (sb.due_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[char_class_automaton_runner] OK");
    end else begin
      $display("[char_class_automaton_runner] ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run, long gaps and stalls included.
  initial begin : watchdog
    #18_000_000;
    $display("[char_class_automaton_runner] ERROR");
    $finish;
  end

endmodule
